// ===== rtl/tmt_pkg.sv =====
package tmt_pkg;

    localparam int WordW      = 32;
    localparam int NumWords   = 4;
    localparam int AddrW      = 4;
    localparam int FeedShift  = 10;
    localparam int TemperShift = 8;

    localparam logic [WordW-1:0] Low31Mask = 32'h7fff_ffff;

    typedef logic [WordW-1:0] t_word;
    typedef t_word t_state [NumWords];

    typedef enum logic [1:0] {
        REG_FEEDBACK_A = 2'd0,
        REG_FEEDBACK_B = 2'd1,
        REG_TEMPER     = 2'd2
    } t_reg_idx;

    typedef enum logic {
        FUNC_STEP = 1'b0,
        FUNC_SEED = 1'b1
    } t_func;

    typedef struct packed {
        t_word feedback_mask_a;
        t_word feedback_mask_b;
        t_word temper_mask;
    } t_masks;

endpackage

// ===== rtl/tinymt32_linear_generator.sv =====
// the result is registered: valid in the cycle after the item is accepted
// throughput: one item per cycle while results are taken, next-state and tempering in a single registered pass
// the output register frees as its result is taken, so items flow without bubbles
// reset (synchronous, active low): state word3 = 1, other words 0, all masks 0,
// no result pending
module tinymt32_linear_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [tmt_pkg::WordW-1:0]   i_seed_word0,
    input  logic [tmt_pkg::WordW-1:0]   i_seed_word1,
    input  logic [tmt_pkg::WordW-1:0]   i_seed_word2,
    input  logic [tmt_pkg::WordW-1:0]   i_seed_word3,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tmt_pkg::WordW-1:0]   o_random_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmt_pkg::AddrW-1:0]   paddr,
    input  logic [tmt_pkg::WordW-1:0]   pwdata,
    output logic [tmt_pkg::WordW-1:0]   prdata,
    output logic                        pready
);

    tmt_pkg::t_masks w_masks;
    tmt_pkg::t_state r_state;
    tmt_pkg::t_state n_state;
    tmt_pkg::t_word  n_random_word;
    tmt_pkg::t_word  r_random_word;
    logic            r_out_valid;
    logic            w_accept;

    tmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_masks (w_masks)
    );

    tmt_step u_step (
        .i_state      (r_state),
        .i_masks      (w_masks),
        .i_func       (i_func),
        .i_seed_word0 (i_seed_word0),
        .i_seed_word1 (i_seed_word1),
        .i_seed_word2 (i_seed_word2),
        .i_seed_word3 (i_seed_word3),
        .o_state      (n_state),
        .o_word       (n_random_word)
    );

    assign o_in_ready    = !r_out_valid || i_out_ready;
    assign w_accept      = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_random_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state[0]  <= '0;
            r_state[1]  <= '0;
            r_state[2]  <= '0;
            r_state[3]  <= tmt_pkg::t_word'(1);
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_random_word <= n_random_word;
        end
    end

endmodule

// ===== rtl/tmt_cfg.sv =====
module tmt_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmt_pkg::AddrW-1:0]   paddr,
    input  logic [tmt_pkg::WordW-1:0]   pwdata,
    output logic [tmt_pkg::WordW-1:0]   prdata,
    output logic                        pready,
    output tmt_pkg::t_masks             o_masks
);

    tmt_pkg::t_masks   r_masks;
    tmt_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = tmt_pkg::t_reg_idx'(paddr[tmt_pkg::AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_masks = r_masks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                tmt_pkg::REG_FEEDBACK_A: r_masks.feedback_mask_a <= pwdata;
                tmt_pkg::REG_FEEDBACK_B: r_masks.feedback_mask_b <= pwdata;
                tmt_pkg::REG_TEMPER:     r_masks.temper_mask     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tmt_pkg::REG_FEEDBACK_A: prdata = r_masks.feedback_mask_a;
            tmt_pkg::REG_FEEDBACK_B: prdata = r_masks.feedback_mask_b;
            tmt_pkg::REG_TEMPER:     prdata = r_masks.temper_mask;
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tmt_step.sv =====
module tmt_step (
    input  tmt_pkg::t_state  i_state,
    input  tmt_pkg::t_masks  i_masks,
    input  logic             i_func,
    input  tmt_pkg::t_word   i_seed_word0,
    input  tmt_pkg::t_word   i_seed_word1,
    input  tmt_pkg::t_word   i_seed_word2,
    input  tmt_pkg::t_word   i_seed_word3,
    output tmt_pkg::t_state  o_state,
    output tmt_pkg::t_word   o_word
);

    tmt_pkg::t_word  w_x0;
    tmt_pkg::t_word  w_x;
    tmt_pkg::t_word  w_y;
    tmt_pkg::t_word  w_t1;
    tmt_pkg::t_word  w_mix;
    tmt_pkg::t_state w_adv;
    tmt_pkg::t_state w_seed;
    logic            w_degen;

    // one step of the recurrence
    always_comb begin
        w_x0 = (i_state[0] & tmt_pkg::Low31Mask) ^ i_state[1] ^ i_state[2];
        w_x  = w_x0 ^ (w_x0 << 1);
        w_y  = i_state[3] ^ (i_state[3] >> 1) ^ w_x;
        w_adv[0] = i_state[1];
        w_adv[1] = i_state[2];
        w_adv[2] = w_x ^ (w_y << tmt_pkg::FeedShift);
        w_adv[3] = w_y;
        if (w_y[0]) begin
            w_adv[1] = w_adv[1] ^ i_masks.feedback_mask_a;
            w_adv[2] = w_adv[2] ^ i_masks.feedback_mask_b;
        end
    end

    // seed load, a seed that is zero apart from bit 31 of word0 is forced to a valid state (word3 = 1)
    always_comb begin
        w_degen = ((i_seed_word0 & tmt_pkg::Low31Mask) == '0) && (i_seed_word1 == '0)
                  && (i_seed_word2 == '0) && (i_seed_word3 == '0);
        w_seed[0] = i_seed_word0;
        w_seed[1] = i_seed_word1;
        w_seed[2] = i_seed_word2;
        w_seed[3] = w_degen ? tmt_pkg::t_word'(1) : i_seed_word3;
    end

    always_comb begin
        unique case (tmt_pkg::t_func'(i_func))
            tmt_pkg::FUNC_SEED: o_state = w_seed;
            default:            o_state = w_adv;
        endcase
    end

    // tempering of the new state
    always_comb begin
        w_t1  = o_state[0] ^ (o_state[2] >> tmt_pkg::TemperShift);
        w_mix = o_state[3] ^ w_t1;
        o_word = w_t1[0] ? (w_mix ^ i_masks.temper_mask) : w_mix;
    end

endmodule
